// File: rtl/bcc_pkg.sv
`timescale 1ns / 1ps

package bcc_pkg;

  // One input transaction: a poll tick with the raw level, or a restart.
  typedef struct packed {
    logic func;
    logic pressed;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0] action_code;
    logic [1:0] relay_command;
    logic [1:0] long_press_report;
    logic [2:0] button_phase;
  } out_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRESSED1 = 3'd1,
    PH_PAUSE1   = 3'd2,
    PH_PRESSED2 = 3'd3,
    PH_PAUSE2   = 3'd4,
    PH_PRESSED3 = 3'd5,
    PH_LONG     = 3'd6,
    PH_BLOCKED  = 3'd7
  } phase_e;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_SWITCH_MODE = 2'd0;
  localparam logic [1:0] REG_RELAY_MODE  = 2'd1;
  localparam logic [1:0] REG_MAX_PAUSE   = 2'd2;
  localparam logic [1:0] REG_LONG_PRESS  = 2'd3;

  localparam logic [1:0] SM_TOGGLE    = 2'd0;
  localparam logic [1:0] SM_MOMENTARY = 2'd1;
  localparam logic [1:0] SM_MULTI     = 2'd2;

  localparam logic [2:0] RM_UNLINKED = 3'd0;
  localparam logic [2:0] RM_FRONT    = 3'd1;
  localparam logic [2:0] RM_SINGLE   = 3'd2;
  localparam logic [2:0] RM_DOUBLE   = 3'd3;
  localparam logic [2:0] RM_TRIPLE   = 3'd4;
  localparam logic [2:0] RM_LONG     = 3'd5;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_SINGLE   = 3'd1;
  localparam logic [2:0] ACT_DOUBLE   = 3'd2;
  localparam logic [2:0] ACT_TRIPLE   = 3'd3;
  localparam logic [2:0] ACT_PRESSED  = 3'd4;
  localparam logic [2:0] ACT_RELEASED = 3'd5;

  localparam logic [1:0] RC_NONE   = 2'd0;
  localparam logic [1:0] RC_TOGGLE = 2'd1;
  localparam logic [1:0] RC_ON     = 2'd2;
  localparam logic [1:0] RC_OFF    = 2'd3;

  localparam logic [1:0] LP_NONE  = 2'd0;
  localparam logic [1:0] LP_BEGAN = 2'd1;
  localparam logic [1:0] LP_ENDED = 2'd2;

  localparam logic [1:0]  SWITCH_MODE_RST = 2'd0;
  localparam logic [2:0]  RELAY_MODE_RST  = 3'd1;
  localparam logic [15:0] MAX_PAUSE_RST   = 16'd25;
  localparam logic [15:0] LONG_PRESS_RST  = 16'd100;

endpackage

// File: rtl/button_click_classifier_core.sv
`timescale 1ns / 1ps

// Button click classifier: debounces a polled button level and reports
// clicks, double and triple clicks, long presses and relay commands.
// Input channel: in_valid_i / in_stall_o / in_data_i, one poll tick or a
// restart command per transaction. Output channel: out_valid_o / out_stall_i
// / out_data_o, exactly one result per input transaction, in order.
// The whole update of one tick is one level of logic between the state
// registers and the output register, so a transaction may be accepted in
// every cycle while the receiver does not stall; its result is then shown
// on the cycle after acceptance. On a stall the output register holds its
// result and one further transaction enters a skid register; in_stall_o rises
// until the output drains. Unstalled throughput is one transaction per cycle.
// Configuration is written over the APB-style port (byte address 4*index);
// every register write also restarts the machine into the blocked phase.
// Reset loads the register defaults, clears the debounce state, puts the
// machine into the blocked phase and empties the output stages. The blocked
// phase is left by the first settled released tick.
module button_click_classifier_core #(
  parameter int SETTLE_TICKS     = 3,
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bcc_pkg::in_t         in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bcc_pkg::out_t        out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int SettleW = $clog2(SETTLE_TICKS + 2);
  localparam int CmpW    = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;
  localparam logic [SettleW-1:0] SettleLim = SettleW'(SETTLE_TICKS);

  // Configuration registers.
  logic [1:0]  switch_mode_q;
  logic [2:0]  relay_mode_q;
  logic [15:0] max_pause_q;
  logic [15:0] long_press_q;

  // Machine state.
  logic                        last_level_q, last_level_d;
  logic [SettleW-1:0]          settle_q, settle_d;
  bcc_pkg::phase_e             phase_q, phase_d;
  logic [TICK_COUNT_WIDTH-1:0] ticks_q, ticks_d;

  // Output register and skid register.
  logic          out_valid_q, skid_valid_q;
  bcc_pkg::out_t out_data_q, skid_data_q;
  bcc_pkg::out_t res;

  logic cfg_wr, in_fire, out_fire;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign in_stall_o  = skid_valid_q;
  assign in_fire  = in_valid_i & ~skid_valid_q;
  assign out_fire = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    case (paddr[3:2])
      bcc_pkg::REG_SWITCH_MODE: prdata = {30'd0, switch_mode_q};
      bcc_pkg::REG_RELAY_MODE:  prdata = {29'd0, relay_mode_q};
      bcc_pkg::REG_MAX_PAUSE:   prdata = {16'd0, max_pause_q};
      bcc_pkg::REG_LONG_PRESS:  prdata = {16'd0, long_press_q};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      switch_mode_q <= bcc_pkg::SWITCH_MODE_RST;
      relay_mode_q  <= bcc_pkg::RELAY_MODE_RST;
      max_pause_q   <= bcc_pkg::MAX_PAUSE_RST;
      long_press_q  <= bcc_pkg::LONG_PRESS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        bcc_pkg::REG_SWITCH_MODE: switch_mode_q <= pwdata[1:0];
        bcc_pkg::REG_RELAY_MODE:  relay_mode_q  <= pwdata[2:0];
        bcc_pkg::REG_MAX_PAUSE:   max_pause_q   <= pwdata[15:0];
        bcc_pkg::REG_LONG_PRESS:  long_press_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Next-state and result logic for one tick.
  logic                        settle_base;
  logic [SettleW-1:0]          settle_mid;
  logic                        settled;
  logic [TICK_COUNT_WIDTH-1:0] ticks_inc;
  logic                        over_long, over_pause, linked;
  logic                        go_en;
  bcc_pkg::phase_e             go_ph;
  logic [2:0]                  act;
  logic [1:0]                  relay, lp;

  always_comb begin
    settle_base = (in_data_i.pressed != last_level_q);
    settle_mid  = settle_base ? '0 : settle_q;
    settle_d    = (settle_mid <= SettleLim) ? settle_mid + SettleW'(1) : settle_mid;
    settled     = (settle_d > SettleLim);
    ticks_inc   = (ticks_q != '1) ? ticks_q + TICK_COUNT_WIDTH'(1) : ticks_q;
    over_long   = CmpW'(ticks_inc) > CmpW'(long_press_q);
    over_pause  = CmpW'(ticks_inc) > CmpW'(max_pause_q);
    linked      = (relay_mode_q != bcc_pkg::RM_UNLINKED);

    last_level_d = last_level_q;
    ticks_d      = ticks_q;
    go_en        = 1'b0;
    go_ph        = bcc_pkg::PH_IDLE;
    act          = bcc_pkg::ACT_NONE;
    relay        = bcc_pkg::RC_NONE;
    lp           = bcc_pkg::LP_NONE;

    if (in_data_i.func) begin
      // Restart leaves the debounce state untouched.
      settle_d = settle_q;
      go_en    = 1'b1;
      go_ph    = bcc_pkg::PH_BLOCKED;
    end else begin
      last_level_d = in_data_i.pressed;
      if (settled) begin
        ticks_d = ticks_inc;
        if (phase_q == bcc_pkg::PH_BLOCKED) begin
          if (!in_data_i.pressed) begin
            go_en = 1'b1;
            go_ph = bcc_pkg::PH_IDLE;
          end
        end else begin
          case (switch_mode_q)
            bcc_pkg::SM_TOGGLE: begin
              if (phase_q == bcc_pkg::PH_IDLE) begin
                if (in_data_i.pressed) begin
                  go_en = 1'b1;
                  go_ph = bcc_pkg::PH_PRESSED1;
                  act   = bcc_pkg::ACT_SINGLE;
                  if (linked) relay = bcc_pkg::RC_TOGGLE;
                end
              end else if (phase_q == bcc_pkg::PH_PRESSED1) begin
                if (!in_data_i.pressed) begin
                  go_en = 1'b1;
                  go_ph = bcc_pkg::PH_IDLE;
                end
              end else begin
                go_en = 1'b1;
                go_ph = bcc_pkg::PH_IDLE;
              end
            end
            bcc_pkg::SM_MOMENTARY: begin
              if (phase_q == bcc_pkg::PH_IDLE) begin
                if (in_data_i.pressed) begin
                  go_en = 1'b1;
                  go_ph = bcc_pkg::PH_PRESSED1;
                  act   = bcc_pkg::ACT_PRESSED;
                  lp    = bcc_pkg::LP_BEGAN;
                  if (linked) relay = bcc_pkg::RC_ON;
                end
              end else if (phase_q == bcc_pkg::PH_PRESSED1) begin
                if (!in_data_i.pressed) begin
                  go_en = 1'b1;
                  go_ph = bcc_pkg::PH_IDLE;
                  act   = bcc_pkg::ACT_RELEASED;
                  lp    = bcc_pkg::LP_ENDED;
                  if (linked) relay = bcc_pkg::RC_OFF;
                end
              end else begin
                go_en = 1'b1;
                go_ph = bcc_pkg::PH_IDLE;
              end
            end
            bcc_pkg::SM_MULTI: begin
              case (phase_q)
                bcc_pkg::PH_IDLE: begin
                  if (in_data_i.pressed) begin
                    go_en = 1'b1;
                    go_ph = bcc_pkg::PH_PRESSED1;
                    if (relay_mode_q == bcc_pkg::RM_FRONT) relay = bcc_pkg::RC_TOGGLE;
                  end
                end
                bcc_pkg::PH_PRESSED1: begin
                  if (!in_data_i.pressed) begin
                    go_en = 1'b1;
                    go_ph = bcc_pkg::PH_PAUSE1;
                  end else if (over_long) begin
                    go_en = 1'b1;
                    go_ph = bcc_pkg::PH_LONG;
                    act   = bcc_pkg::ACT_PRESSED;
                    lp    = bcc_pkg::LP_BEGAN;
                    if (relay_mode_q == bcc_pkg::RM_LONG) relay = bcc_pkg::RC_ON;
                  end
                end
                bcc_pkg::PH_PAUSE1: begin
                  if (in_data_i.pressed) begin
                    go_en = 1'b1;
                    go_ph = bcc_pkg::PH_PRESSED2;
                  end else if (over_pause) begin
                    go_en = 1'b1;
                    go_ph = bcc_pkg::PH_IDLE;
                    act   = bcc_pkg::ACT_SINGLE;
                    if (relay_mode_q == bcc_pkg::RM_SINGLE) relay = bcc_pkg::RC_TOGGLE;
                  end
                end
                bcc_pkg::PH_PRESSED2: begin
                  if (!in_data_i.pressed) begin
                    go_en = 1'b1;
                    go_ph = bcc_pkg::PH_PAUSE2;
                  end
                end
                bcc_pkg::PH_PAUSE2: begin
                  if (in_data_i.pressed) begin
                    go_en = 1'b1;
                    go_ph = bcc_pkg::PH_PRESSED3;
                  end else if (over_pause) begin
                    go_en = 1'b1;
                    go_ph = bcc_pkg::PH_IDLE;
                    act   = bcc_pkg::ACT_DOUBLE;
                    if (relay_mode_q == bcc_pkg::RM_DOUBLE) relay = bcc_pkg::RC_TOGGLE;
                  end
                end
                bcc_pkg::PH_PRESSED3: begin
                  if (!in_data_i.pressed) begin
                    go_en = 1'b1;
                    go_ph = bcc_pkg::PH_IDLE;
                    act   = bcc_pkg::ACT_TRIPLE;
                    if (relay_mode_q == bcc_pkg::RM_TRIPLE) relay = bcc_pkg::RC_TOGGLE;
                  end
                end
                bcc_pkg::PH_LONG: begin
                  if (!in_data_i.pressed) begin
                    go_en = 1'b1;
                    go_ph = bcc_pkg::PH_IDLE;
                    act   = bcc_pkg::ACT_RELEASED;
                    lp    = bcc_pkg::LP_ENDED;
                    if (relay_mode_q == bcc_pkg::RM_LONG) relay = bcc_pkg::RC_OFF;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
    end

    // A phase change always restarts the tick counter.
    phase_d = phase_q;
    if (go_en) begin
      phase_d = go_ph;
      ticks_d = '0;
    end

    res.action_code       = act;
    res.relay_command     = relay;
    res.long_press_report = lp;
    res.button_phase      = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b0;
      settle_q     <= '0;
      phase_q      <= bcc_pkg::PH_BLOCKED;
      ticks_q      <= '0;
    end else if (cfg_wr) begin
      phase_q <= bcc_pkg::PH_BLOCKED;
      ticks_q <= '0;
    end else if (in_fire) begin
      last_level_q <= last_level_d;
      settle_q     <= settle_d;
      phase_q      <= phase_d;
      ticks_q      <= ticks_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_q <= skid_data_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_data_q <= res;
      end else begin
        skid_data_q <= res;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a transaction while the output is empty");

  a_restart_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.func && !cfg_wr) |=> (phase_q == bcc_pkg::PH_BLOCKED))
    else $error("restart did not put the machine into the blocked phase");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (phase_q == bcc_pkg::PH_BLOCKED && ticks_q == '0))
    else $error("register write did not restart the machine");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result was lost");
`endif

endmodule

// File: verif/tb_button_click_classifier_core.sv
`timescale 1ns / 1ps

module tb_button_click_classifier_core;

  localparam int SETTLE_TICKS = 3;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 60;
  localparam int RANDOM_ITEMS = 115;
  localparam int SOAK_HOLD    = 150;

  // One row of the directed table; exp is only used where typed is set.
  typedef struct packed {
    logic          func;
    logic          pressed;
    logic          typed;
    bcc_pkg::out_t exp;
  } dir_row_t;

  typedef struct packed {
    logic [1:0]  sw;
    logic [2:0]  rm;
    logic [15:0] pause;
    logic [15:0] lng;
    logic        soak;
  } regime_t;

  localparam bcc_pkg::out_t BLK = '{bcc_pkg::ACT_NONE, bcc_pkg::RC_NONE, bcc_pkg::LP_NONE,
                                    bcc_pkg::PH_BLOCKED};
  localparam bcc_pkg::out_t IDL = '{bcc_pkg::ACT_NONE, bcc_pkg::RC_NONE, bcc_pkg::LP_NONE,
                                    bcc_pkg::PH_IDLE};
  localparam bcc_pkg::out_t ANY = '0;

  localparam dir_row_t DIRECTED [24] = '{
    '{1'b0, 1'b0, 1'b1, BLK}, '{1'b0, 1'b1, 1'b1, BLK}, '{1'b0, 1'b0, 1'b1, BLK},
    '{1'b0, 1'b0, 1'b1, BLK}, '{1'b0, 1'b0, 1'b1, BLK}, '{1'b0, 1'b0, 1'b1, IDL},
    '{1'b1, 1'b1, 1'b1, BLK}, '{1'b0, 1'b1, 1'b1, BLK}, '{1'b0, 1'b1, 1'b1, BLK},
    '{1'b0, 1'b1, 1'b1, BLK}, '{1'b0, 1'b1, 1'b1, BLK}, '{1'b0, 1'b0, 1'b1, BLK},
    '{1'b0, 1'b0, 1'b0, ANY}, '{1'b0, 1'b0, 1'b0, ANY}, '{1'b0, 1'b0, 1'b0, ANY},
    '{1'b0, 1'b1, 1'b0, ANY}, '{1'b0, 1'b1, 1'b0, ANY}, '{1'b0, 1'b1, 1'b0, ANY},
    '{1'b0, 1'b1, 1'b0, ANY}, '{1'b0, 1'b0, 1'b0, ANY}, '{1'b0, 1'b0, 1'b0, ANY},
    '{1'b0, 1'b0, 1'b0, ANY}, '{1'b0, 1'b0, 1'b0, ANY}, '{1'b1, 1'b0, 1'b1, BLK}
  };

  localparam regime_t REGIMES [14] = '{
    '{bcc_pkg::SM_MOMENTARY, bcc_pkg::RM_FRONT,    16'd25,   16'd100,  1'b0},
    '{bcc_pkg::SM_MOMENTARY, bcc_pkg::RM_UNLINKED, 16'd5,    16'd5,    1'b0},
    '{bcc_pkg::SM_MULTI,     bcc_pkg::RM_FRONT,    16'd6,    16'd12,   1'b0},
    '{bcc_pkg::SM_MULTI,     bcc_pkg::RM_SINGLE,   16'd0,    16'd0,    1'b0},
    '{bcc_pkg::SM_MULTI,     bcc_pkg::RM_DOUBLE,   16'd8,    16'd20,   1'b0},
    '{bcc_pkg::SM_MULTI,     bcc_pkg::RM_TRIPLE,   16'd5,    16'd15,   1'b0},
    '{bcc_pkg::SM_MULTI,     bcc_pkg::RM_LONG,     16'd10,   16'd10,   1'b0},
    '{bcc_pkg::SM_MULTI,     3'd6,                 16'd4,    16'd9,    1'b0},
    '{bcc_pkg::SM_TOGGLE,    bcc_pkg::RM_UNLINKED, 16'd3,    16'd3,    1'b0},
    '{bcc_pkg::SM_TOGGLE,    3'd7,                 16'd30,   16'd2,    1'b0},
    '{2'd3,                  bcc_pkg::RM_LONG,     16'hFFFF, 16'hFFFF, 1'b0},
    '{bcc_pkg::SM_MULTI,     bcc_pkg::RM_LONG,     16'hFFFF, 16'hFFFF, 1'b1},
    '{bcc_pkg::SM_MOMENTARY, 3'd7,                 16'd7,    16'd7,    1'b0},
    '{bcc_pkg::SM_MULTI,     bcc_pkg::RM_SINGLE,   16'hFFFF, 16'd5,    1'b0}
  };

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  bcc_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  bcc_pkg::out_t out_data;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [3:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  // Predictor copy of the configuration and of the machine state.
  logic [1:0]      cfg_switch = bcc_pkg::SWITCH_MODE_RST;
  logic [2:0]      cfg_relay  = bcc_pkg::RELAY_MODE_RST;
  logic [15:0]     cfg_pause  = bcc_pkg::MAX_PAUSE_RST;
  logic [15:0]     cfg_long   = bcc_pkg::LONG_PRESS_RST;
  logic            lvl_q = 1'b0;
  int              settle_q = 0;
  bcc_pkg::phase_e ph_q = bcc_pkg::PH_BLOCKED;
  logic [15:0]     ticks_q = '0;

  bcc_pkg::out_t pending_reports [$];
  int   report_errors = 0;
  int   quiet_cycles = 0;
  int   snd_idle_pct = 0;
  int   rcv_stall_pct = 0;
  int   hold_left = 0;
  int   hold_asked = 0;
  int   hold_served = 0;

  always #1 clk_i = ~clk_i;

  button_click_classifier_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  function automatic void enter_phase(input bcc_pkg::phase_e p);
    ph_q    = p;
    ticks_q = '0;
  endfunction

  function automatic bcc_pkg::out_t classify_tick(input bcc_pkg::in_t it);
    bcc_pkg::out_t r;
    logic pr;
    logic mom;
    r   = '0;
    pr  = it.pressed;
    mom = (cfg_switch == bcc_pkg::SM_MOMENTARY);
    if (it.func) begin
      enter_phase(bcc_pkg::PH_BLOCKED);
    end else begin
      if (pr != lvl_q) begin
        lvl_q    = pr;
        settle_q = 0;
      end
      if (settle_q <= SETTLE_TICKS) settle_q++;
      if (settle_q > SETTLE_TICKS) begin
        if (ticks_q != 16'hFFFF) ticks_q++;
        if (ph_q == bcc_pkg::PH_BLOCKED) begin
          if (!pr) enter_phase(bcc_pkg::PH_IDLE);
        end else if (cfg_switch == bcc_pkg::SM_TOGGLE || mom) begin
          case (ph_q)
            bcc_pkg::PH_IDLE: begin
              if (pr) begin
                enter_phase(bcc_pkg::PH_PRESSED1);
                r.action_code = mom ? bcc_pkg::ACT_PRESSED : bcc_pkg::ACT_SINGLE;
                if (cfg_relay != bcc_pkg::RM_UNLINKED)
                  r.relay_command = mom ? bcc_pkg::RC_ON : bcc_pkg::RC_TOGGLE;
                if (mom) r.long_press_report = bcc_pkg::LP_BEGAN;
              end
            end
            bcc_pkg::PH_PRESSED1: begin
              if (!pr) begin
                enter_phase(bcc_pkg::PH_IDLE);
                if (mom) begin
                  r.action_code       = bcc_pkg::ACT_RELEASED;
                  r.long_press_report = bcc_pkg::LP_ENDED;
                  if (cfg_relay != bcc_pkg::RM_UNLINKED) r.relay_command = bcc_pkg::RC_OFF;
                end
              end
            end
            default: enter_phase(bcc_pkg::PH_IDLE);
          endcase
        end else if (cfg_switch == bcc_pkg::SM_MULTI) begin
          case (ph_q)
            bcc_pkg::PH_IDLE: begin
              if (pr) begin
                enter_phase(bcc_pkg::PH_PRESSED1);
                if (cfg_relay == bcc_pkg::RM_FRONT) r.relay_command = bcc_pkg::RC_TOGGLE;
              end
            end
            bcc_pkg::PH_PRESSED1: begin
              if (!pr) begin
                enter_phase(bcc_pkg::PH_PAUSE1);
              end else if (ticks_q > cfg_long) begin
                enter_phase(bcc_pkg::PH_LONG);
                r.action_code       = bcc_pkg::ACT_PRESSED;
                r.long_press_report = bcc_pkg::LP_BEGAN;
                if (cfg_relay == bcc_pkg::RM_LONG) r.relay_command = bcc_pkg::RC_ON;
              end
            end
            bcc_pkg::PH_PAUSE1: begin
              if (pr) begin
                enter_phase(bcc_pkg::PH_PRESSED2);
              end else if (ticks_q > cfg_pause) begin
                enter_phase(bcc_pkg::PH_IDLE);
                r.action_code = bcc_pkg::ACT_SINGLE;
                if (cfg_relay == bcc_pkg::RM_SINGLE) r.relay_command = bcc_pkg::RC_TOGGLE;
              end
            end
            bcc_pkg::PH_PRESSED2: begin
              if (!pr) enter_phase(bcc_pkg::PH_PAUSE2);
            end
            bcc_pkg::PH_PAUSE2: begin
              if (pr) begin
                enter_phase(bcc_pkg::PH_PRESSED3);
              end else if (ticks_q > cfg_pause) begin
                enter_phase(bcc_pkg::PH_IDLE);
                r.action_code = bcc_pkg::ACT_DOUBLE;
                if (cfg_relay == bcc_pkg::RM_DOUBLE) r.relay_command = bcc_pkg::RC_TOGGLE;
              end
            end
            bcc_pkg::PH_PRESSED3: begin
              if (!pr) begin
                enter_phase(bcc_pkg::PH_IDLE);
                r.action_code = bcc_pkg::ACT_TRIPLE;
                if (cfg_relay == bcc_pkg::RM_TRIPLE) r.relay_command = bcc_pkg::RC_TOGGLE;
              end
            end
            bcc_pkg::PH_LONG: begin
              if (!pr) begin
                enter_phase(bcc_pkg::PH_IDLE);
                r.action_code       = bcc_pkg::ACT_RELEASED;
                r.long_press_report = bcc_pkg::LP_ENDED;
                if (cfg_relay == bcc_pkg::RM_LONG) r.relay_command = bcc_pkg::RC_OFF;
              end
            end
            default: ;
          endcase
        end
      end
    end
    r.button_phase = ph_q;
    return r;
  endfunction

  function automatic int run_len(input logic [15:0] lim);
    int cap;
    cap = (lim > 16'd40) ? 40 : int'(lim);
    case ($urandom_range(9))
      0:       return $urandom_range(1, 3);
      1, 2:    return SETTLE_TICKS + 2 + cap + $urandom_range(1, 6);
      default: return $urandom_range(SETTLE_TICKS + 1, SETTLE_TICKS + 2 + cap);
    endcase
  endfunction

  // Called and left at a falling edge. The expectation is queued at the
  // accepting edge, before the result can appear.
  task automatic push_tick(input bcc_pkg::in_t it, input logic typed,
                           input bcc_pkg::out_t exp);
    bcc_pkg::out_t pred;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    pred = classify_tick(it);
    pending_reports.push_back(typed ? exp : pred);
    @(negedge clk_i);
  endtask

  task automatic drive_run(input logic lvl, input int len);
    bcc_pkg::in_t it;
    it.func    = 1'b0;
    it.pressed = lvl;
    repeat (len) push_tick(it, 1'b0, ANY);
  endtask

  // Each call opens a fresh setup phase, so psel stays high across a burst.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      bcc_pkg::REG_SWITCH_MODE: cfg_switch = val[1:0];
      bcc_pkg::REG_RELAY_MODE:  cfg_relay  = val[2:0];
      bcc_pkg::REG_MAX_PAUSE:   cfg_pause  = val[15:0];
      bcc_pkg::REG_LONG_PRESS:  cfg_long   = val[15:0];
      default: ;
    endcase
    enter_phase(bcc_pkg::PH_BLOCKED);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic flag_report(input string what, input bcc_pkg::out_t exp,
                             input bcc_pkg::out_t got);
    report_errors++;
    if (report_errors <= 10)
      $display("%0t %s: exp act=%0d rly=%0d lp=%0d ph=%0d got act=%0d rly=%0d lp=%0d ph=%0d",
               $realtime, what, exp.action_code, exp.relay_command,
               exp.long_press_report, exp.button_phase, got.action_code,
               got.relay_command, got.long_press_report, got.button_phase);
  endtask

  always @(negedge clk_i) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    bcc_pkg::out_t exp;
    bit            busy;
    if (rst_ni) begin
      busy = (in_valid && !in_stall) || (psel && penable);
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (pending_reports.size() == 0) begin
          flag_report("unexpected result", ANY, out_data);
        end else begin
          exp = pending_reports.pop_front();
          if (out_data.action_code !== exp.action_code ||
              out_data.relay_command !== exp.relay_command ||
              out_data.long_press_report !== exp.long_press_report ||
              out_data.button_phase !== exp.button_phase)
            flag_report("mismatch", exp, out_data);
        end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_button_click_classifier_core: FAIL");
        $finish;
      end
    end
  end

  initial begin
    regime_t      r;
    bcc_pkg::in_t it;
    int           sent;
    int           len;
    logic         lvl;
    logic [31:0]  val;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i]) begin
      it.func    = DIRECTED[i].func;
      it.pressed = DIRECTED[i].pressed;
      push_tick(it, DIRECTED[i].typed, DIRECTED[i].exp);
    end

    foreach (REGIMES[k]) begin
      r = REGIMES[k];
      wait_drained();
      // Upper bits of each write are random; only the register width counts.
      val = $urandom; val[1:0]  = r.sw;    write_reg(bcc_pkg::REG_SWITCH_MODE, val);
      val = $urandom; val[2:0]  = r.rm;    write_reg(bcc_pkg::REG_RELAY_MODE, val);
      val = $urandom; val[15:0] = r.pause; write_reg(bcc_pkg::REG_MAX_PAUSE, val);
      val = $urandom; val[15:0] = r.lng;   write_reg(bcc_pkg::REG_LONG_PRESS, val);
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;

      if (r.soak) begin
        // A long hold with the limit at its maximum must never turn long.
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        drive_run(1'b0, 8);
        drive_run(1'b1, SOAK_HOLD);
        drive_run(1'b0, 8);
      end else begin
        snd_idle_pct  = (k % 4 == 1) ? 86 : (k % 4 == 3) ? 15 : 0;
        rcv_stall_pct = (k % 4 == 2) ? 86 : (k % 4 == 3) ? 15 : 0;
        if (k % 4 == 0) hold_asked++;
        sent = 0;
        lvl  = 1'b0;
        while (sent < RANDOM_ITEMS) begin
          if ($urandom_range(29) == 0) begin
            it.func    = 1'b1;
            it.pressed = $urandom_range(1);
            push_tick(it, 1'b0, ANY);
            sent++;
          end else begin
            lvl = ~lvl;
            len = run_len(lvl ? r.lng : r.pause);
            drive_run(lvl, len);
            sent += len;
          end
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (report_errors == 0 && pending_reports.size() == 0) begin
      $display("tb_button_click_classifier_core: PASS");
    end else begin
      $display("tb_button_click_classifier_core: FAIL");
    end
    $finish;
  end

endmodule
